/* hdl/lpfd_pkg.sv */
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared constants and types for the length-prefixed frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

    localparam int HEADER_BYTES = 14;
    localparam int MAGIC_END    = 4;
    localparam int EVENT_END    = 6;
    localparam int SEQ_END      = 10;

    localparam int IDX_W = $clog2(HEADER_BYTES + 1);

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'd1;

    localparam logic [30:0] MAX_LEN_RESET = 31'd65536;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] evt_id;
        logic [31:0] seq_number;
        logic [30:0] payload_len;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

/* hdl/lpfd_core.sv */
// ----------------------------------------------------------------------------
// lpfd_core
// Header gathering, header check and payload byte counting, one byte per
// transfer; the result for the byte is produced in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_core
    import lpfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_magic_word,
    input  wire logic [30:0] i_max_len,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [IDX_W-1:0] r_hdr_idx,    n_hdr_idx;
    logic             r_in_payload, n_in_payload;
    logic [31:0]      r_magic,      n_magic;
    logic [15:0]      r_event,      n_event;
    logic [31:0]      r_seq,        n_seq;
    logic [31:0]      r_length,     n_length;
    logic [30:0]      r_bytes_left, n_bytes_left;
    logic             pay_active;
    logic             bad_hdr;

    assign pay_active = r_in_payload && (r_bytes_left != '0);

    always_comb begin
        n_hdr_idx    = r_hdr_idx;
        n_in_payload = r_in_payload;
        n_magic      = r_magic;
        n_event      = r_event;
        n_seq        = r_seq;
        n_length     = r_length;
        n_bytes_left = r_bytes_left;
        bad_hdr      = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_step) begin
            if (pay_active) begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_PAYLOAD;
                o_res.evt_id       = r_event;
                o_res.seq_number   = r_seq;
                o_res.payload_len  = r_length[30:0];
                o_res.payload_byte = i_data_byte;
                o_res.last         = (r_bytes_left == 31'd1);
                n_bytes_left       = r_bytes_left - 31'd1;
                n_in_payload       = (r_bytes_left != 31'd1);
            end else begin
                n_in_payload = 1'b0;
                if (r_hdr_idx < IDX_W'(MAGIC_END)) begin
                    n_magic = {i_data_byte, r_magic[31:8]};
                end else if (r_hdr_idx < IDX_W'(EVENT_END)) begin
                    n_event = {i_data_byte, r_event[15:8]};
                end else if (r_hdr_idx < IDX_W'(SEQ_END)) begin
                    n_seq = {i_data_byte, r_seq[31:8]};
                end else begin
                    n_length = {i_data_byte, r_length[31:8]};
                end

                if (r_hdr_idx < IDX_W'(HEADER_BYTES - 1)) begin
                    n_hdr_idx = r_hdr_idx + IDX_W'(1);
                end else begin
                    n_hdr_idx   = '0;
                    bad_hdr     = (n_magic != i_magic_word) || n_length[31]
                                  || (n_length[30:0] > i_max_len);
                    o_res_valid      = 1'b1;
                    o_res.evt_id     = n_event;
                    o_res.seq_number = n_seq;
                    if (bad_hdr) begin
                        o_res.kind = KIND_BAD;
                        o_res.last = 1'b1;
                    end else begin
                        o_res.kind        = KIND_HEADER;
                        o_res.payload_len = n_length[30:0];
                        o_res.last        = (n_length[30:0] == '0);
                        if (n_length[30:0] != '0) begin
                            n_bytes_left = n_length[30:0];
                            n_in_payload = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= '0;
            r_in_payload <= 1'b0;
            r_magic      <= '0;
            r_event      <= '0;
            r_seq        <= '0;
            r_length     <= '0;
            r_bytes_left <= '0;
        end else begin
            r_hdr_idx    <= n_hdr_idx;
            r_in_payload <= n_in_payload;
            r_magic      <= n_magic;
            r_event      <= n_event;
            r_seq        <= n_seq;
            r_length     <= n_length;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

`default_nettype wire

/* hdl/length_prefixed_frame_decoder_unit.sv */
// Output: a result is registered and appears in the cycle after its input transfer.
// Throughput: one input byte per cycle; the input stalls only while a result
// waits in the output register and the receiver is not ready.
// Reset: synchronous, active low; clears the header counter, payload state,
// output valid, and sets magic word to 0 and max payload length to 65536.
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_unit
// Byte-stream deframer: magic/length-prefixed header check and payload pass.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_decoder_unit
    import lpfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_data_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_kind,
    output logic [15:0]               o_evt_id,
    output logic [31:0]               o_seq_number,
    output logic [30:0]               o_payload_len,
    output logic [7:0]                o_payload_byte,
    output logic                      o_last
);

    logic [31:0] r_magic_word;
    logic [30:0] r_max_len;
    logic        r_out_valid;
    t_result     r_out;
    logic        step;
    logic        res_valid;
    t_result     res;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word <= '0;
            r_max_len    <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAGIC_WORD: r_magic_word <= i_cfg_data;
                CFG_MAX_LEN:    r_max_len    <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    lpfd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (i_data_byte),
        .i_magic_word (r_magic_word),
        .i_max_len    (r_max_len),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // hold result until transfer; load a new one on each accepted byte that yields a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_evt_id       = r_out.evt_id;
    assign o_seq_number   = r_out.seq_number;
    assign o_payload_len  = r_out.payload_len;
    assign o_payload_byte = r_out.payload_byte;
    assign o_last         = r_out.last;

endmodule

`default_nettype wire
